### rtl/enma_pkg.sv
`timescale 1ns / 1ps
// enma_pkg: shared types and constants for the edge-normalized moving average.
// Holds the payload structs, register codes and state encodings; no dependencies.
package enma_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AVG_W    = 24;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [CFG_W-1:0] HALF_WINDOW_RST = 6'd4;

  // Register index codes (byte address / 4)
  localparam logic REG_HALF_WINDOW = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } enma_in_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    last_result;
  } enma_out_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_UPD,
    SEQ_EMIT,
    SEQ_DR_CHK,
    SEQ_DR_SUB,
    SEQ_DR_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

### rtl/enma_ring.sv
`timescale 1ns / 1ps
// enma_ring: sample ring memory, one write port and one registered read port.
// Depends on enma_pkg for the sample width.
module enma_ring #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [enma_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic                                rd_en_i,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [enma_pkg::SAMPLE_W-1:0] rd_data_o
);
  import enma_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/enma_div.sv
`timescale 1ns / 1ps
// enma_div: serial restoring divider producing round(256 * sum / count), plus output register.
// Depends on enma_pkg for widths, the result struct and state encoding.
module enma_div #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned SUM_W = 23
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  logic signed [SUM_W-1:0] job_sum_i,
  input  logic [CNT_W-1:0]      job_count_i,
  input  logic                  job_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output enma_pkg::enma_out_t   out_data_o
);
  import enma_pkg::*;

  localparam int unsigned MAG_W = SUM_W - 1;
  localparam int unsigned DVD_W = MAG_W + FRAC_W + 1;
  localparam int unsigned QUO_W = AVG_W;
  localparam int unsigned IT_W  = $clog2(QUO_W);

  div_state_e state_q, state_d;
  logic start, step, load, out_free;

  logic                    neg_q, last_q;
  logic [CNT_W-1:0]        div_q, rem_q;
  logic [QUO_W-1:0]        quo_q;
  logic [IT_W-1:0]         it_q;
  logic                    out_valid_q;
  enma_out_t               out_q;

  logic signed [SUM_W-1:0] abs_sum;
  logic [DVD_W-1:0]        dividend;
  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [CNT_W-1:0]        rem_nxt;
  logic [QUO_W-1:0]        avg_val;

  // dividend = |sum| * 256 + count / 2; the quotient always fits QUO_W bits,
  // so the bits above QUO_W seed the partial remainder
  always_comb begin
    abs_sum  = job_sum_i[SUM_W-1] ? -job_sum_i : job_sum_i;
    dividend = {1'b0, abs_sum[MAG_W-1:0], {FRAC_W{1'b0}}} + DVD_W'(job_count_i >> 1);
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[QUO_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, div_q}) : CNT_W'(rem_sh);
    avg_val = neg_q ? (~quo_q + QUO_W'(1)) : quo_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and controls
  always_comb begin
    state_d     = state_q;
    start       = 1'b0;
    step        = 1'b0;
    load        = 1'b0;
    job_ready_o = 1'b0;
    case (state_q)
      DIV_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          start   = 1'b1;
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        step = 1'b1;
        if (it_q == IT_W'(QUO_W - 1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start) begin
      neg_q  <= job_sum_i[SUM_W-1];
      last_q <= job_last_i;
      div_q  <= job_count_i;
      rem_q  <= CNT_W'(dividend >> QUO_W);
      quo_q  <= dividend[QUO_W-1:0];
      it_q   <= '0;
    end else if (step) begin
      rem_q  <= rem_nxt;
      quo_q  <= {quo_q[QUO_W-2:0], ge};
      it_q   <= it_q + IT_W'(1);
    end
    if (load) begin
      out_q.average     <= avg_val;
      out_q.last_result <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/enma_seq.sv
`timescale 1ns / 1ps
// enma_seq: sequencer for window sum, sample count and ring head; drives the ring and
// hands (sum, count) jobs to the divider. Depends on enma_pkg.
module enma_seq #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned H_W   = 6,
  parameter int unsigned SUM_W = 23
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic [H_W-1:0]                      half_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  enma_pkg::enma_in_t                  in_data_i,
  output logic                                wr_en_o,
  output logic [AW-1:0]                       wr_addr_o,
  output logic signed [enma_pkg::SAMPLE_W-1:0] wr_data_o,
  output logic                                rd_en_o,
  output logic [AW-1:0]                       rd_addr_o,
  input  logic signed [enma_pkg::SAMPLE_W-1:0] rd_data_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic signed [SUM_W-1:0]             job_sum_o,
  output logic [CNT_W-1:0]                    job_count_o,
  output logic                                job_last_o
);
  import enma_pkg::*;

  seq_state_e state_q, state_d;

  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           seen_q, seen_d;
  logic [AW-1:0]              head_q, head_d;
  logic [H_W-1:0]             k_q, k_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       last_q, last_d;
  logic                       sub_q, sub_d;

  logic [CNT_W-1:0]           twice_h, half_c, seen_new, seen_m1;
  logic signed [SUM_W-1:0]    old_val;

  // slot that lies span entries behind head, modulo the ring depth
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] head,
                                              input logic [CNT_W-1:0] span);
    logic signed [CNT_W+1:0] diff;
    diff = $signed({2'b00, CNT_W'(head)}) - $signed({2'b00, span});
    if (diff < 0) begin
      diff = diff + (CNT_W+2)'(DEPTH);
    end
    return AW'(diff);
  endfunction

  always_comb begin
    half_c   = CNT_W'(half_i);
    twice_h  = CNT_W'({half_i, 1'b0});
    old_val  = sub_q ? SUM_W'(rd_data_i) : '0;
    seen_new = sub_q ? twice_h : seen_q + CNT_W'(1);
    seen_m1  = seen_new - CNT_W'(1);
  end

  // next state, ring accesses and job hand-off
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    head_d      = head_q;
    k_d         = k_q;
    sample_d    = sample_q;
    last_d      = last_q;
    sub_d       = sub_q;
    in_stall_o  = 1'b1;
    wr_en_o     = 1'b0;
    wr_addr_o   = head_q;
    wr_data_o   = sample_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = ring_back(head_q, twice_h);
    job_valid_o = 1'b0;
    job_sum_o   = sum_q;
    job_count_o = seen_q;
    job_last_o  = (state_q == SEQ_DR_EMIT) && (k_q == '0);

    case (state_q)
      SEQ_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          sample_d = in_data_i.sample;
          last_d   = in_data_i.last_sample;
          // full window: fetch the sample that drops out
          sub_d    = seen_q >= twice_h;
          rd_en_o  = seen_q >= twice_h;
          state_d  = SEQ_UPD;
        end
      end
      SEQ_UPD: begin
        // old sample was read last cycle, so the write is safe even when it hits the same slot
        wr_en_o = 1'b1;
        sum_d   = sum_q - old_val + SUM_W'(sample_q);
        seen_d  = seen_new;
        head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        if (!last_q) begin
          state_d = (seen_new > half_c) ? SEQ_EMIT : SEQ_IDLE;
        end else begin
          k_d     = (seen_m1 < half_c) ? H_W'(seen_m1) : half_i;
          state_d = SEQ_DR_CHK;
        end
      end
      SEQ_EMIT: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end
      SEQ_DR_CHK: begin
        // drop the oldest sample while the window still reaches past the tail
        if (seen_q > CNT_W'(k_q) + half_c) begin
          rd_en_o   = 1'b1;
          rd_addr_o = ring_back(head_q, seen_q);
          state_d   = SEQ_DR_SUB;
        end else begin
          state_d = SEQ_DR_EMIT;
        end
      end
      SEQ_DR_SUB: begin
        sum_d   = sum_q - SUM_W'(rd_data_i);
        seen_d  = seen_q - CNT_W'(1);
        state_d = SEQ_DR_CHK;
      end
      SEQ_DR_EMIT: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          if (k_q == '0) begin
            sum_d   = '0;
            seen_d  = '0;
            head_d  = '0;
            state_d = SEQ_IDLE;
          end else begin
            k_d     = k_q - H_W'(1);
            state_d = SEQ_DR_CHK;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    // a half_window write abandons the waveform in progress
    if (clear_i) begin
      sum_d  = '0;
      seen_d = '0;
      head_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      sum_q   <= '0;
      seen_q  <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    sample_q <= sample_d;
    last_q   <= last_d;
    sub_q    <= sub_d;
  end

endmodule

### rtl/edge_normalized_moving_average.sv
`timescale 1ns / 1ps
// edge_normalized_moving_average: top level, APB register, sequencer, ring and divider.
// Throughput is set by the 24-step serial divider, which takes no new job until its result
// is loaded into the output register; a last sample drains up to h+1 averages. Reset clears
// the sum, count and ring head and loads half_window with 4; the ring memory is not
// cleared (only fresh entries are read).
module edge_normalized_moving_average #(
  parameter int unsigned MAX_HALF_WINDOW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [enma_pkg::APB_AW-1:0]   paddr,
  input  logic [enma_pkg::APB_DW-1:0]   pwdata,
  output logic [enma_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  enma_pkg::enma_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output enma_pkg::enma_out_t           out_data_o
);
  import enma_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_HALF_WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned H_W   = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(DEPTH) + 1;

  logic [CFG_W-1:0]           half_window_q;
  logic                       reg_idx;
  logic                       cfg_wr;
  logic [H_W-1:0]             h_eff;

  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic signed [SAMPLE_W-1:0] wr_data, rd_data;

  logic                       job_valid, job_ready, job_last;
  logic signed [SUM_W-1:0]    job_sum;
  logic [CNT_W-1:0]           job_count;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_HALF_WINDOW);
  assign prdata  = (reg_idx == REG_HALF_WINDOW) ? APB_DW'(half_window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= HALF_WINDOW_RST;
    end else if (cfg_wr) begin
      half_window_q <= pwdata[CFG_W-1:0];
    end
  end

  // clamp the half window to 1 .. MAX_HALF_WINDOW
  always_comb begin
    if (half_window_q == '0) begin
      h_eff = H_W'(1);
    end else if (32'(half_window_q) > MAX_HALF_WINDOW) begin
      h_eff = H_W'(MAX_HALF_WINDOW);
    end else begin
      h_eff = H_W'(half_window_q);
    end
  end

  enma_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W),
    .H_W   (H_W),
    .SUM_W (SUM_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_wr),
    .half_i      (h_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_sum_o   (job_sum),
    .job_count_o (job_count),
    .job_last_o  (job_last)
  );

  enma_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  enma_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_sum_i   (job_sum),
    .job_count_i (job_count),
    .job_last_i  (job_last),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // divisor handed to the divider is a real clipped window count
  a_job_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |-> job_count != '0 && 32'(job_count) <= 2 * 32'(h_eff))
    else $error("divider job count out of range");

  // the final average of a waveform covers at most h samples
  a_last_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready && job_last |-> 32'(job_count) <= 32'(h_eff))
    else $error("final window count exceeds half window");

  // one sample at a time: the sequencer is busy right after a transfer
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous sample in progress");

endmodule

### sim/edge_normalized_moving_average_test.sv
`timescale 1ns / 1ps
// edge_normalized_moving_average_test: self-checking testbench for the moving average block.
// Depends on enma_pkg and edge_normalized_moving_average; predicts each windowed mean
// in a scoreboard class and checks every output transfer against it.
module edge_normalized_moving_average_test;
  import enma_pkg::*;

  localparam int unsigned MAX_HW     = 32;
  localparam int unsigned RING_DEPTH = 2 * MAX_HW;
  localparam int unsigned REG_UNUSED = 1;     // first index past the register map
  localparam int SETTLE_CYCLES = 64;          // covers a sample still in flight
  localparam int FINAL_SETTLE  = 120;
  localparam int IDLE_LIMIT    = 6000;
  localparam int PHASE_ITEMS   = 16;
  localparam int NUM_PHASES    = 12;
  localparam int HOLD_CYCLES   = 500;
  localparam int MAX_REPORTS   = 10;

  // half window as the block uses it: zero counts as one, large values clamp
  function automatic int clamp_half(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_HW) return MAX_HW;
    return int'(v);
  endfunction

  // Running-sum predictor of the windowed means plus the queue of pending averages
  class average_scoreboard;
    logic [CFG_W-1:0] half_window;
    shortint          ring [RING_DEPTH];
    longint           window_sum;
    int               seen;
    int               head;
    enma_out_t        expected_averages[$];
    int               errors;
    int               samples_in;
    int               waveforms;
    int               averages_checked;

    function new();
      half_window = HALF_WINDOW_RST;
      clear();
    endfunction

    function void clear();
      window_sum = 0;
      seen       = 0;
      head       = 0;
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    // a half_window write drops any waveform in progress
    function void write_register(int unsigned index, logic [CFG_W-1:0] value);
      if (index == REG_HALF_WINDOW) begin
        half_window = value;
        clear();
      end
    endfunction

    function void flag_mismatch(string what, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Q.8 mean, rounded to nearest on the magnitude
    function void push_average(longint total, int count, bit is_last);
      longint    mag;
      longint    q;
      enma_out_t e;
      mag = (total < 0) ? -total : total;
      q = (mag * 256 + count / 2) / count;
      if (total < 0) q = -q;
      e.average     = q[AVG_W-1:0];
      e.last_result = is_last;
      expected_averages.push_back(e);
    endfunction

    function void note_sample(enma_in_t t);
      int h;
      int have;
      int kmax;
      h = clamp_half(half_window);
      samples_in++;
      if (seen >= 2 * h) begin
        window_sum -= ring[(head + RING_DEPTH - 2 * h) % RING_DEPTH];
        seen = 2 * h;
      end else begin
        seen++;
      end
      ring[head] = shortint'(t.sample);
      head = (head + 1) % RING_DEPTH;
      window_sum += shortint'(t.sample);
      if (!t.last_sample) begin
        if (seen > h) push_average(window_sum, seen, 1'b0);
        return;
      end
      // end of waveform: emit the tail while the window shrinks from the left
      have = seen;
      kmax = (seen - 1 < h) ? seen - 1 : h;
      for (int k = kmax; k >= 0; k--) begin
        while (have > k + h) begin
          window_sum -= ring[(head + RING_DEPTH - have) % RING_DEPTH];
          have--;
        end
        push_average(window_sum, have, k == 0);
      end
      waveforms++;
      clear();
    endfunction

    function void check_average(enma_out_t got);
      enma_out_t want;
      if (expected_averages.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected average %0d (last %0b)", $time, got.average,
                   got.last_result);
        return;
      end
      want = expected_averages.pop_front();
      averages_checked++;
      if (got.average !== want.average)
        flag_mismatch("average", want.average, got.average);
      if (got.last_result !== want.last_result)
        flag_mismatch("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  enma_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  enma_out_t           out_data_o;

  average_scoreboard sb = new();
  bit                quiet_mode;
  int                hold_req;
  int                hold_left;
  int                stall_run;
  int                stall_pick;
  int                idle_cycles;
  int                config_writes;

  edge_normalized_moving_average #(
    .MAX_HALF_WINDOW(MAX_HW)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Output side: check each transfer, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_average(out_data_o);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_mode || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 20);
      end else if (stall_pick < 92) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(20, 80);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer, %0d averages outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("** edge_normalized_moving_average: FAILED **");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return SAMPLE_W'($urandom);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return SAMPLE_W'($urandom_range(0, 600)) - 16'd300;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input bit is_last);
    enma_in_t t;
    int       gap;
    t.sample      = value;
    t.last_sample = is_last;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(t);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending, wait for every pending average, then let the block settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register write with junk in the upper data bits; half_window is read back
  task automatic write_config(input int unsigned index, input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] wd;
    logic [APB_DW-1:0] rd;
    wd = $urandom;
    wd[CFG_W-1:0] = value;
    quiesce();
    apb_access(1'b1, APB_AW'(4 * index), wd, rd);
    sb.write_register(index, value);
    config_writes++;
    if (index == REG_HALF_WINDOW) begin
      apb_access(1'b0, APB_AW'(4 * index), '0, rd);
      if (rd[CFG_W-1:0] !== value) sb.flag_mismatch("half_window readback", value, rd[CFG_W-1:0]);
    end
  endtask

  initial begin
    logic [CFG_W-1:0]  hv;
    logic [APB_DW-1:0] rd;
    int                eh;
    int                r;
    int                len;
    int                phase_items;
    int                pause_at;
    bit                cut;

    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of half_window
    apb_access(1'b0, APB_AW'(4 * REG_HALF_WINDOW), '0, rd);
    if (rd[CFG_W-1:0] !== HALF_WINDOW_RST)
      sb.flag_mismatch("half_window after reset", HALF_WINDOW_RST, rd[CFG_W-1:0]);

    // Directed: single-sample waveforms at both extremes, then a short one
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    // longer than the full window so old samples are subtracted
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFE, 1'b1);
    // zero half window behaves as one
    write_config(REG_HALF_WINDOW, 6'd0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    // oversized half window clamps to the maximum
    write_config(REG_HALF_WINDOW, 6'd63);
    send_sample(16'hFFFD, 1'b1);
    // a register write abandons a partial waveform
    write_config(REG_HALF_WINDOW, 6'd2);
    send_sample(16'd100, 1'b0);
    send_sample(16'hFFF9, 1'b0);
    send_sample(16'd5, 1'b0);
    write_config(REG_HALF_WINDOW, 6'd3);
    // a write past the register map leaves the waveform alone
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    write_config(REG_UNUSED, 6'h2A);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'hFFF7, 1'b0);
    send_sample(16'h7FFF, 1'b1);

    // Random phases, each starting with a half window write
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       hv = 6'd1;
        1:       hv = 6'd32;
        2:       hv = 6'd0;
        3:       hv = 6'd63;
        4:       hv = 6'd33;
        5:       hv = 6'd2;
        6:       hv = 6'd7;
        7:       hv = 6'd16;
        11:      hv = 6'd32;
        default: hv = CFG_W'($urandom_range(0, 63));
      endcase
      write_config(REG_HALF_WINDOW, hv);
      eh = clamp_half(hv);
      quiet_mode = (p % 4 == 3);
      if (p == 0) begin
        // output held off while inputs stream in back to back: the block must back up
        quiet_mode = 1'b1;
        hold_req   = HOLD_CYCLES;
        for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample(), i == PHASE_ITEMS - 1);
        quiet_mode = 1'b0;
      end else begin
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
          r = $urandom_range(0, 99);
          if (r < 8) len = 1;
          else if (r < 50) len = $urandom_range(2, 2 * eh);
          else len = $urandom_range(2 * eh + 1, 2 * eh + eh / 2 + 2);
          // the phase's final waveform is sometimes left open for the next write to drop
          cut = (phase_items + len >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
          pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
          for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(), (i == len - 1) && !cut);
            if (i == pause_at) begin
              quiesce();
              if ($urandom_range(0, 1) == 1) write_config(REG_UNUSED, CFG_W'($urandom));
            end
          end
          phase_items += len;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (FINAL_SETTLE) @(posedge clk_i);

    $display("Run covered %0d samples, %0d closed waveforms, %0d averages checked, %0d writes.",
             sb.samples_in, sb.waveforms, sb.averages_checked, config_writes);
    $display("Half windows 0 to 63 incl. clamping, dropped waveforms, long output hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** edge_normalized_moving_average: PASSED **");
    end else begin
      $display("%0d errors, %0d averages never arrived", sb.errors, sb.pending());
      $display("** edge_normalized_moving_average: FAILED **");
    end
    $finish;
  end

endmodule
